// ===== design/frspc_pkg.sv =====
`default_nettype none

package frspc_pkg;

   localparam int MAX_POINTS = 16;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Full Q.30 product of Q8.8 point, Q1.14 trig value and Q8.8 scale.
   localparam int PROD_W     = 49;
   localparam int FRAC_SHIFT = 30;
   localparam int PIX_W      = PROD_W - FRAC_SHIFT + 1;

   localparam logic [10:0] SCREEN_LIMIT = 11'd1024;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd5;

   // Quarter wave of round(16384 * sin(d)), d = 0..90 degrees.
   localparam logic [14:0] QSINE [91] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
      15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
      15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
      15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
      15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
      15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
      15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
      15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
      15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
      15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
      15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
      15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
      15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
      15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
      15'd16384
   };

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic [9:0] screen_x;
      logic [9:0] screen_y;
      logic       move_to;
      logic       final_res;
      logic       off_screen;
   } rsp_type;

   typedef struct packed {
      logic [8:0]         angle_deg;
      logic [15:0]        scale_factor;
      logic signed [11:0] offset_x;
      logic signed [11:0] offset_y;
      logic [10:0]        screen_width;
      logic [10:0]        screen_height;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              issue;
      logic [ADDR_W-1:0] addr;
      logic              first;
      logic              last;
      logic              emit_mode;
      logic              emit_off;
      logic              clear_off;
   } cmd_type;

   typedef struct packed {
      logic adv;
      logic pipe_empty;
      logic any_off;
   } status_type;

   // Sine in Q1.14 for 0 <= deg < 720.
   function automatic logic signed [15:0] sine_q14(input logic [9:0] deg);
      logic [9:0] d;
      logic [6:0] r;
      logic       neg;
      logic signed [15:0] mag;
      d = (deg >= 10'd360) ? deg - 10'd360 : deg;
      if (d < 10'd90) begin
         r   = d[6:0];
         neg = 1'b0;
      end else if (d < 10'd180) begin
         r   = 7'(10'd180 - d);
         neg = 1'b0;
      end else if (d < 10'd270) begin
         r   = 7'(d - 10'd180);
         neg = 1'b1;
      end else begin
         r   = 7'(10'd360 - d);
         neg = 1'b1;
      end
      mag = $signed({1'b0, QSINE[r]});
      return neg ? -mag : mag;
   endfunction

   function automatic logic [10:0] clamp_screen(input logic [10:0] v);
      return (v > SCREEN_LIMIT) ? SCREEN_LIMIT : v;
   endfunction

endpackage

`default_nettype wire

// ===== design/frspc_ram.sv =====
`default_nettype none

module frspc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/frspc_csr.sv =====
`default_nettype none

module frspc_csr import frspc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   logic    ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff             <= 1'b0;
         cfg_ff.angle_deg     <= 9'd0;
         cfg_ff.scale_factor  <= 16'd512;
         cfg_ff.offset_x      <= 12'sd160;
         cfg_ff.offset_y      <= 12'sd100;
         cfg_ff.screen_width  <= 11'd320;
         cfg_ff.screen_height <= 11'd200;
      end else begin
         ready_ff <= 1'b1;
         if (csr_valid && ready_ff) begin
            case (csr_index)
               CSR_ANGLE:    cfg_ff.angle_deg     <= csr_wdata[8:0];
               CSR_SCALE:    cfg_ff.scale_factor  <= csr_wdata;
               CSR_OFFSET_X: cfg_ff.offset_x      <= $signed(csr_wdata[11:0]);
               CSR_OFFSET_Y: cfg_ff.offset_y      <= $signed(csr_wdata[11:0]);
               CSR_WIDTH:    cfg_ff.screen_width  <= csr_wdata[10:0];
               CSR_HEIGHT:   cfg_ff.screen_height <= csr_wdata[10:0];
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = ready_ff;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// ===== design/frspc_ctrl.sv =====
`default_nettype none

module frspc_ctrl import frspc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CHECK_WAIT,
      ST_OFF,
      ST_EMIT,
      ST_EMIT_WAIT
   } state_type;

   state_type         state_ff, state_in;
   logic              stall_ff, stall_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   logic accept;
   logic has_room;
   logic idx_last;

   assign accept   = (state_ff == ST_IDLE) && req_valid && !stall_ff;
   assign has_room = count_ff < CNT_W'(MAX_POINTS);
   assign idx_last = (CNT_W'(idx_ff) + CNT_W'(1)) == num_ff;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      count_in = count_ff;
      num_in   = num_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            stall_in = 1'b0;
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  num_in   = has_room ? count_ff + CNT_W'(1) : count_ff;
                  count_in = '0;
                  idx_in   = '0;
                  stall_in = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.adv) begin
               idx_in = idx_ff + ADDR_W'(1);
               if (idx_last) begin
                  state_in = ST_CHECK_WAIT;
               end
            end
         end
         ST_CHECK_WAIT: begin
            if (status.pipe_empty) begin
               idx_in   = '0;
               state_in = status.any_off ? ST_OFF : ST_EMIT;
            end
         end
         ST_OFF: begin
            if (status.adv) begin
               state_in = ST_IDLE;
               stall_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (status.adv) begin
               idx_in = idx_ff + ADDR_W'(1);
               if (idx_last) begin
                  state_in = ST_EMIT_WAIT;
               end
            end
         end
         ST_EMIT_WAIT: begin
            if (status.pipe_empty) begin
               state_in = ST_IDLE;
               stall_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
         count_ff <= '0;
         num_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
         count_ff <= count_in;
         num_ff   <= num_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      cmd.wr_en     = accept && has_room;
      cmd.wr_addr   = count_ff[ADDR_W-1:0];
      cmd.issue     = (state_ff == ST_CHECK) || (state_ff == ST_EMIT);
      cmd.addr      = idx_ff;
      cmd.first     = (idx_ff == '0);
      cmd.last      = idx_last;
      cmd.emit_mode = (state_ff == ST_EMIT) || (state_ff == ST_EMIT_WAIT);
      cmd.emit_off  = (state_ff == ST_OFF);
      cmd.clear_off = accept && req_last;
   end

   assign req_stall = stall_ff;

endmodule

`default_nettype wire

// ===== design/frspc_dpath.sv =====
`default_nettype none

module frspc_dpath import frspc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   input  wire logic    rsp_stall,
   output status_type   status,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic        adv;
   logic [31:0] ram_rd;

   // Rotation and screen constants, refreshed every cycle from the registers.
   logic [8:0]         ang;
   logic signed [15:0] cos_ff, cos_in, sin_ff, sin_in;
   logic [10:0]        wid_ff, wid_in, hgt_ff, hgt_in;

   // Pipeline: 0 RAM read, 1 products, 2 rotate sums, 3 scale, 4 place and check.
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic f0_ff, f1_ff, f2_ff, f3_ff, f4_ff;
   logic l0_ff, l1_ff, l2_ff, l3_ff, l4_ff;

   logic signed [15:0] x0, y0;
   logic signed [31:0] xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [31:0] xc_in, ys_in, xs_in, yc_in;
   logic signed [31:0] rx_ff, ry_ff, rx_in, ry_in;
   logic signed [16:0] scale_s;
   logic signed [PROD_W-1:0] p_ff, q_ff, p_in, q_in;
   logic [PIX_W-1:0] px_int, py_int;
   logic [9:0]       px_ff, py_ff;
   logic             on_ff, on_in;

   logic    any_off_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   frspc_ram #(
      .WIDTH(32),
      .DEPTH(MAX_POINTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(cmd.wr_addr),
      .wr_data({req_data.point_x, req_data.point_y}),
      .rd_en  (adv),
      .rd_addr(cmd.addr),
      .rd_data(ram_rd)
   );

   always_comb begin
      ang    = (cfg.angle_deg >= 9'd360) ? cfg.angle_deg - 9'd360 : cfg.angle_deg;
      sin_in = sine_q14({1'b0, ang});
      cos_in = sine_q14({1'b0, ang} + 10'd90);
      wid_in = clamp_screen(cfg.screen_width);
      hgt_in = clamp_screen(cfg.screen_height);
   end

   always_comb begin
      x0      = $signed(ram_rd[31:16]);
      y0      = $signed(ram_rd[15:0]);
      xc_in   = x0 * cos_ff;
      ys_in   = y0 * sin_ff;
      xs_in   = x0 * sin_ff;
      yc_in   = y0 * cos_ff;
      rx_in   = xc_ff - ys_ff;
      ry_in   = xs_ff + yc_ff;
      scale_s = $signed({1'b0, cfg.scale_factor});
      p_in    = rx_ff * scale_s;
      q_in    = ry_ff * scale_s;
      // Offsets are whole pixels, so only the integer part of the product
      // takes part in the add. The y inversion subtracts, so a nonzero
      // fraction rounds the integer part up before it is subtracted.
      px_int  = $unsigned($signed(p_ff[PROD_W-1:FRAC_SHIFT])
                + PIX_W'(cfg.offset_x));
      py_int  = PIX_W'(hgt_ff) - PIX_W'(cfg.offset_y)
                - $unsigned(PIX_W'($signed(q_ff[PROD_W-1:FRAC_SHIFT])))
                - PIX_W'(|q_ff[FRAC_SHIFT-1:0]);
      on_in   = !px_int[PIX_W-1] && (px_int < PIX_W'(wid_ff))
                && !py_int[PIX_W-1] && (py_int < PIX_W'(hgt_ff));
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      wid_ff <= wid_in;
      hgt_ff <= hgt_in;
      if (adv) begin
         f0_ff <= cmd.first;
         l0_ff <= cmd.last;
         f1_ff <= f0_ff;
         l1_ff <= l0_ff;
         f2_ff <= f1_ff;
         l2_ff <= l1_ff;
         f3_ff <= f2_ff;
         l3_ff <= l2_ff;
         f4_ff <= f3_ff;
         l4_ff <= l3_ff;
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         p_ff  <= p_in;
         q_ff  <= q_in;
         px_ff <= px_int[9:0];
         py_ff <= py_int[9:0];
         on_ff <= on_in;
         if (cmd.emit_off) begin
            rsp_data_ff.screen_x   <= '0;
            rsp_data_ff.screen_y   <= '0;
            rsp_data_ff.move_to    <= 1'b0;
            rsp_data_ff.final_res  <= 1'b1;
            rsp_data_ff.off_screen <= 1'b1;
         end else begin
            rsp_data_ff.screen_x   <= px_ff;
            rsp_data_ff.screen_y   <= py_ff;
            rsp_data_ff.move_to    <= f4_ff;
            rsp_data_ff.final_res  <= l4_ff;
            rsp_data_ff.off_screen <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         any_off_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            v0_ff        <= cmd.issue;
            v1_ff        <= v0_ff;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            v4_ff        <= v3_ff;
            rsp_valid_ff <= cmd.emit_off || (v4_ff && cmd.emit_mode);
         end
         if (cmd.clear_off) begin
            any_off_ff <= 1'b0;
         end else if (adv && v4_ff && !cmd.emit_mode && !on_ff) begin
            any_off_ff <= 1'b1;
         end
      end
   end

   assign status.adv        = adv;
   assign status.pipe_empty = !(v0_ff || v1_ff || v2_ff || v3_ff || v4_ff);
   assign status.any_off    = any_off_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/figure_rotate_scale_place_clip.sv =====
// Figure rotate, scale, place and clip.
// Points enter on the req_ channel (Q8.8 x and y plus an is_last mark) and
// are written into a 16-entry point memory, one transaction per cycle while
// req_stall is low. Points beyond 16 are dropped, but a dropped point marked
// last still ends the figure. On the last point req_stall rises and the
// figure is run through a five-stage pipeline (memory read, products,
// rotation sums, scale, placement and screen check): first a check pass,
// then either an emit pass that sends one rsp_ transaction per point, or a
// single off-screen result. After the last point the block stays busy for
// each pass, set by one pipeline slot per point plus its fill and drain; an
// off-screen figure gives its one result and frees the input once the check
// pass has drained.
// Results may still wait in the output register while the next figure loads.
// When rsp_stall is high while a result waits, the whole pipeline holds and
// resumes without loss. The user writes registers on the csr_ channel only
// while no figure is in progress; the block does not enforce it. Reset is
// synchronous: registers take their defaults, the point count clears, and
// req_stall drops in the cycle after reset falls.
`default_nettype none

module figure_rotate_scale_place_clip import frspc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   frspc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   frspc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_last (req_data.is_last),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   frspc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_stall(rsp_stall),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // The off-screen transaction is only sent after the check pass failed.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_off |-> status.any_off)
      else $error("off-screen result without a failed check");

   // The emit pass only runs for a figure that passed the check.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_mode |-> !status.any_off)
      else $error("emit pass on a figure that failed the check");

   // Loading points and reading them back never overlap.
   assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (!cmd.issue && status.pipe_empty))
      else $error("point write during a pass");

   // An off-screen result is the whole run: final, no move, zero coordinates.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.off_screen) |->
         (rsp_data.final_res && !rsp_data.move_to
          && rsp_data.screen_x == '0 && rsp_data.screen_y == '0))
      else $error("malformed off-screen result");

endmodule

`default_nettype wire
